// ----- rtl/bfrc_pkg.sv -----
// ----------------------------------------------------------------------------
// bfrc_pkg: block frame receive checker package
// Shared constants, types and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package bfrc_pkg;

  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'h8408;
  localparam logic [7:0]  StartMark  = 8'hA5;
  localparam logic [7:0]  PcbTopMask = 8'hE0;
  localparam logic [7:0]  PcbRBlock  = 8'h80;
  localparam logic [7:0]  PcbErrMask = 8'h03;
  localparam logic [8:0]  FrameOverhead = 9'd5;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CRC_ERR = 2'd1,
    STATUS_PCB_ERR = 2'd2
  } bfrc_status_e;

  typedef struct packed {
    logic         is_status;
    logic [7:0]   payload_byte;
    logic [7:0]   control_byte;
    logic [8:0]   frame_length;
    bfrc_status_e status;
    logic         last;
  } bfrc_result_t;

  // Reflected CRC-16 update over one byte, unrolled bit by bit.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ----- rtl/block_frame_receive_checker_top.sv -----
// ----------------------------------------------------------------------------
// block_frame_receive_checker_top: block frame receive checker
// Deframes marker/control/length/payload/CRC-16 frames and reports status.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   in      | input     | in_valid_i / in_stall_o | rx_byte_i
//   out     | output    | out_valid_o / out_stall_i | is_status_o, payload_byte_o,
//           |           |                         | control_byte_o, frame_length_o,
//           |           |                         | status_o, last_o
//
// One byte request is taken per cycle while in_stall_o is low; its result
// (if any) is registered in the result register, or in the skid stage while
// the output is stalled, behind the parser's combinational CRC step.
// A byte gives at most one result: payload bytes and the high CRC byte do.
// Reset (rst_ni low, asynchronous) returns the parser to hunting for the
// start marker and empties the result register and the skid stage.
// An output stall holds the result; the skid stage takes one more result,
// after which in_stall_o rises until the output takes a result.
// ----------------------------------------------------------------------------
module block_frame_receive_checker_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_status_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] control_byte_o,
  output logic [8:0] frame_length_o,
  output logic [1:0] status_o,
  output logic       last_o
);

  logic                   accept;
  logic                   res_valid;
  logic                   buf_full;
  bfrc_pkg::bfrc_result_t res;
  bfrc_pkg::bfrc_result_t out_data;

  // Stall input only while the skid stage is occupied.
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  bfrc_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  bfrc_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  // Unpack the result register onto the field ports.
  assign is_status_o    = out_data.is_status;
  assign payload_byte_o = out_data.payload_byte;
  assign control_byte_o = out_data.control_byte;
  assign frame_length_o = out_data.frame_length;
  assign status_o       = out_data.status;
  assign last_o         = out_data.last;

  a_status_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_status_o |-> last_o && payload_byte_o == 8'd0)
    else $error("status result with payload or without last");

  a_payload_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_status_o |-> !last_o && frame_length_o == 9'd0)
    else $error("payload result with status fields set");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o) else $error("input stalled with output empty");

endmodule

// ----- rtl/bfrc_parser.sv -----
// ----------------------------------------------------------------------------
// bfrc_parser: frame parser
// Tracks frame position, runs the CRC and builds payload and status results.
// ----------------------------------------------------------------------------
module bfrc_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            rx_byte_i,
  output logic                  res_valid_o,
  output bfrc_pkg::bfrc_result_t res_o
);

  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_CTRL    = 6'b000010,
    PH_LEN     = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CRCLO   = 6'b010000,
    PH_CRCHI   = 6'b100000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  control_q, control_d;
  logic [7:0]  remaining_q, remaining_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [7:0]  length_q, length_d;
  logic [15:0] crc_next;
  logic [15:0] crc_fin;

  assign crc_next = bfrc_pkg::crc_byte(crc_q, rx_byte_i);
  assign crc_fin  = ~crc_q;

  always_comb begin
    phase_d     = phase_q;
    control_d   = control_q;
    remaining_d = remaining_q;
    crc_d       = crc_q;
    crc_lo_d    = crc_lo_q;
    length_d    = length_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      case (phase_q)
        PH_CTRL: begin
          control_d = rx_byte_i;
          crc_d     = crc_next;
          phase_d   = PH_LEN;
        end
        PH_LEN: begin
          length_d    = rx_byte_i;
          remaining_d = rx_byte_i;
          crc_d       = crc_next;
          phase_d     = (rx_byte_i == 8'd0) ? PH_CRCLO : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          crc_d       = crc_next;
          remaining_d = remaining_q - 8'd1;
          if (remaining_q == 8'd1) begin
            phase_d = PH_CRCLO;
          end
          res_valid_o        = 1'b1;
          res_o.payload_byte = rx_byte_i;
          res_o.control_byte = control_q;
        end
        PH_CRCLO: begin
          crc_lo_d = rx_byte_i;
          phase_d  = PH_CRCHI;
        end
        PH_CRCHI: begin
          res_valid_o        = 1'b1;
          res_o.is_status    = 1'b1;
          res_o.control_byte = control_q;
          res_o.frame_length = {1'b0, length_q} + bfrc_pkg::FrameOverhead;
          res_o.last         = 1'b1;
          // CRC mismatch wins over an error-reporting control block.
          if (crc_lo_q != crc_fin[7:0] || rx_byte_i != crc_fin[15:8]) begin
            res_o.status = bfrc_pkg::STATUS_CRC_ERR;
          end else if ((control_q & bfrc_pkg::PcbTopMask) == bfrc_pkg::PcbRBlock &&
                       (control_q & bfrc_pkg::PcbErrMask) != 8'd0) begin
            res_o.status = bfrc_pkg::STATUS_PCB_ERR;
          end else begin
            res_o.status = bfrc_pkg::STATUS_OK;
          end
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
          if (rx_byte_i == bfrc_pkg::StartMark) begin
            crc_d   = bfrc_pkg::crc_byte(bfrc_pkg::CrcInit, rx_byte_i);
            phase_d = PH_CTRL;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      control_q   <= '0;
      remaining_q <= '0;
      crc_q       <= bfrc_pkg::CrcInit;
      crc_lo_q    <= '0;
      length_q    <= '0;
    end else begin
      phase_q     <= phase_d;
      control_q   <= control_d;
      remaining_q <= remaining_d;
      crc_q       <= crc_d;
      crc_lo_q    <= crc_lo_d;
      length_q    <= length_d;
    end
  end

  a_res_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> accept_i) else $error("result without accepted byte");

  a_status_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.is_status |=> phase_q == PH_HUNT)
    else $error("status did not return to hunting");

  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> remaining_q != 8'd0)
    else $error("payload phase with nothing remaining");

endmodule

// ----- rtl/bfrc_out_buf.sv -----
// ----------------------------------------------------------------------------
// bfrc_out_buf: result register with skid stage
// Holds results for the output channel and stalls the input when full.
// ----------------------------------------------------------------------------
module bfrc_out_buf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  bfrc_pkg::bfrc_result_t push_data_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output bfrc_pkg::bfrc_result_t out_data_o
);

  logic                   out_v_q, out_v_d;
  logic                   skid_v_q, skid_v_d;
  bfrc_pkg::bfrc_result_t out_q, out_d;
  bfrc_pkg::bfrc_result_t skid_q, skid_d;
  logic                   pop;

  assign pop         = out_v_q && !out_stall_i;
  assign full_o      = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      // Drain the skid stage into the output register.
      if (pop) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (out_v_q && !pop) begin
        skid_d   = push_data_i;
        skid_v_d = 1'b1;
      end else begin
        out_d   = push_data_i;
        out_v_d = 1'b1;
      end
    end else if (pop) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid holds data with output empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(push_i && out_v_q && out_stall_i))
    else $error("skid filled without a stalled output");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> !push_i) else $error("request pushed while full");

endmodule

// ----- sim/block_frame_receive_checker_top_test.sv -----
// ----------------------------------------------------------------------------
// block_frame_receive_checker_top_test: block frame receive checker testbench
// Sends byte requests that form marker/control/length/payload/CRC-16 frames,
// mixed with line noise and broken frames. A cycle-free predictor of the
// deframer runs on every accepted request and queues the expected payload and
// status results. A checker compares each accepted result field by field,
// while both sides insert random gaps and the receiver once holds off long
// enough to fill the block and stall its input.
// ----------------------------------------------------------------------------
module block_frame_receive_checker_top_test;

  // Quiet cycles (no request and no result taken) that end the run.
  localparam int QuietLimit = 2000;
  // Length of the receiver hold-off in the backpressure test.
  localparam int HoldCycles = 160;
  // Cycles to let pass after the last expected result.
  localparam int TailCycles = 8;

  // Parser phases of the predictor.
  typedef enum logic [2:0] {
    RX_HUNT,
    RX_CONTROL,
    RX_LENGTH,
    RX_DATA,
    RX_FCS_LO,
    RX_FCS_HI
  } rx_phase_e;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i    = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic       is_status_o;
  logic [7:0] payload_byte_o;
  logic [7:0] control_byte_o;
  logic [8:0] frame_length_o;
  logic [1:0] status_o;
  logic       last_o;

  // Predictor state: mirrors the deframer after every accepted request.
  rx_phase_e   rx_phase  = RX_HUNT;
  logic [7:0]  cur_ctrl  = 8'h00;
  logic [8:0]  data_left = 9'd0;
  logic [15:0] fcs_acc   = bfrc_pkg::CrcInit;
  logic [7:0]  fcs_lo    = 8'h00;
  logic [7:0]  cur_len   = 8'h00;

  // Results still owed by the block, oldest first.
  bfrc_pkg::bfrc_result_t pending_results[$];
  bfrc_pkg::bfrc_result_t want_res;

  int  mismatch_cnt = 0;
  int  quiet_cycles = 0;
  // Percentage of requests/cycles that get a gap; zero turns idling off.
  int  gap_pct      = 30;
  int  stall_left   = 0;
  // Set by a test to make the receiver hold off for HoldCycles.
  bit  hold_req     = 1'b0;

  block_frame_receive_checker_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_status_o    (is_status_o),
    .payload_byte_o (payload_byte_o),
    .control_byte_o (control_byte_o),
    .frame_length_o (frame_length_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  always #4 clk_i = ~clk_i;

  // Serial LSB-first form of the reflected CRC-16: feed one data bit per step.
  function automatic logic [15:0] fcs_update(input logic [15:0] acc,
                                             input logic [7:0]  b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ b[i];
      acc = {1'b0, acc[15:1]} ^ (fb ? bfrc_pkg::CrcPoly : 16'h0000);
    end
    return acc;
  endfunction

  // Draw a gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    if (gap_pct == 0 || $urandom_range(99) >= gap_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  // Advance the predictor by one accepted byte and queue any result it owes.
  task automatic predict_rx_byte(input logic [7:0] b);
    bfrc_pkg::bfrc_result_t res;
    logic [15:0]            fcs_final;
    res = '0;
    case (rx_phase)
      RX_CONTROL: begin
        cur_ctrl = b;
        fcs_acc  = fcs_update(fcs_acc, b);
        rx_phase = RX_LENGTH;
      end
      RX_LENGTH: begin
        cur_len   = b;
        data_left = {1'b0, b};
        fcs_acc   = fcs_update(fcs_acc, b);
        // Zero length: the next byte is already the low CRC byte.
        rx_phase  = (b == 8'h00) ? RX_FCS_LO : RX_DATA;
      end
      RX_DATA: begin
        fcs_acc   = fcs_update(fcs_acc, b);
        data_left = data_left - 9'd1;
        if (data_left == 9'd0) rx_phase = RX_FCS_LO;
        res.payload_byte = b;
        res.control_byte = cur_ctrl;
        res.status       = bfrc_pkg::STATUS_OK;
        pending_results.push_back(res);
      end
      RX_FCS_LO: begin
        fcs_lo   = b;
        rx_phase = RX_FCS_HI;
      end
      RX_FCS_HI: begin
        fcs_final        = ~fcs_acc;
        res.is_status    = 1'b1;
        res.control_byte = cur_ctrl;
        res.frame_length = {1'b0, cur_len} + bfrc_pkg::FrameOverhead;
        res.last         = 1'b1;
        // A CRC mismatch wins over an error-reporting control byte.
        if ({b, fcs_lo} != fcs_final) begin
          res.status = bfrc_pkg::STATUS_CRC_ERR;
        end else if ((cur_ctrl & bfrc_pkg::PcbTopMask) == bfrc_pkg::PcbRBlock &&
                     (cur_ctrl & bfrc_pkg::PcbErrMask) != 8'h00) begin
          res.status = bfrc_pkg::STATUS_PCB_ERR;
        end else begin
          res.status = bfrc_pkg::STATUS_OK;
        end
        pending_results.push_back(res);
        rx_phase = RX_HUNT;
      end
      default: begin
        // Hunt: drop everything but the start marker.
        if (b == bfrc_pkg::StartMark) begin
          fcs_acc  = fcs_update(bfrc_pkg::CrcInit, b);
          rx_phase = RX_CONTROL;
        end
      end
    endcase
  endtask

  // Print one line per mismatch and count every one of them.
  task automatic report_mismatch(input string what, input logic [8:0] got,
                                 input logic [8:0] want);
    mismatch_cnt++;
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // Offer one byte request, hold it until accepted, then feed the predictor.
  // Returns at the falling edge after acceptance with valid still high.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (in_stall_o);
    predict_rx_byte(b);
    @(negedge clk_i);
  endtask

  // Send a whole frame; fcs_flip corrupts the trailing CRC where nonzero.
  task automatic send_frame(input logic [7:0] ctrl, input logic [7:0] body[$],
                            input logic [15:0] fcs_flip);
    logic [15:0] acc;
    logic [7:0]  len;
    len = 8'(body.size());
    acc = fcs_update(bfrc_pkg::CrcInit, bfrc_pkg::StartMark);
    send_byte(bfrc_pkg::StartMark);
    acc = fcs_update(acc, ctrl);
    send_byte(ctrl);
    acc = fcs_update(acc, len);
    send_byte(len);
    foreach (body[i]) begin
      acc = fcs_update(acc, body[i]);
      send_byte(body[i]);
    end
    acc = ~acc ^ fcs_flip;
    send_byte(acc[7:0]);
    send_byte(acc[15:8]);
  endtask

  // Drop valid and wait until every expected result has been taken.
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Noise, then three short frames: marker as control byte with zero length,
  // error-reporting control with payload extremes, and both errors at once
  // with the marker value as payload.
  task automatic test_directed_frames();
    logic [7:0] body[$];
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    body = {};
    send_frame(bfrc_pkg::StartMark, body, 16'h0000);
    body = {8'h00, 8'hFF};
    send_frame(8'h81, body, 16'h0000);
    body = {bfrc_pkg::StartMark};
    send_frame(8'h82, body, 16'h0100);
    drain_results();
  endtask

  // Run frames with no idling on either side.
  task automatic test_back_to_back();
    logic [7:0] body[$];
    gap_pct = 0;
    repeat (6) begin
      body = {};
      repeat ($urandom_range(10)) body.push_back(8'($urandom));
      send_frame(8'($urandom), body, ($urandom_range(3) == 0) ? 16'h8000 : 16'h0000);
    end
    drain_results();
    gap_pct = 30;
  endtask

  // Send the longest frame: 255 payload bytes, frame length 260.
  task automatic test_longest_frame();
    logic [7:0] body[$];
    body = {};
    repeat (255) body.push_back(8'($urandom));
    send_frame(8'h83, body, 16'h0000);
    drain_results();
  endtask

  // Mostly well-formed frames with random content, some with a bad CRC;
  // the rest is line noise and frames cut short after a few bytes.
  task automatic test_random_traffic();
    logic [7:0]  body[$];
    logic [7:0]  ctrl;
    logic [15:0] flip;
    int          sent;
    int          pick;
    int          len;
    sent = 0;
    while (sent < 330) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        if ($urandom_range(3) == 0) begin
          ctrl = {3'b100, 3'($urandom), 2'($urandom_range(3, 1))};
        end else begin
          ctrl = 8'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 70)      len = $urandom_range(6);
        else if (pick < 97) len = $urandom_range(40, 7);
        else                len = $urandom_range(255, 100);
        body = {};
        repeat (len) body.push_back(8'($urandom));
        flip = ($urandom_range(6) == 0) ? 16'($urandom_range(65535, 1)) : 16'h0000;
        send_frame(ctrl, body, flip);
        sent += len + 5;
      end else if (pick < 90) begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      end else begin
        // Broken frame: marker and a few random bytes, then whatever follows.
        len = $urandom_range(6, 1);
        send_byte(bfrc_pkg::StartMark);
        repeat (len) send_byte(8'($urandom));
        sent += len + 1;
      end
    end
    drain_results();
  endtask

  // Hold the receiver off while the sender keeps offering payload requests.
  task automatic test_output_backpressure();
    logic [7:0] body[$];
    gap_pct  = 0;
    hold_req = 1'b1;
    repeat (3) begin
      body = {};
      repeat (20) body.push_back(8'($urandom));
      send_frame(8'($urandom), body, 16'h0000);
    end
    drain_results();
    gap_pct = 30;
  endtask

  // Receiver: random stalls, or one long hold-off when a test asks for it.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req    = 1'b0;
        out_stall_i = 1'b0;
      end else if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
        stall_left  = pick_gap();
      end
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {8'h00, is_status_o}, 9'd0);
      end else begin
        want_res = pending_results.pop_front();
        if (is_status_o !== want_res.is_status)
          report_mismatch("is_status", {8'h00, is_status_o}, {8'h00, want_res.is_status});
        if (payload_byte_o !== want_res.payload_byte)
          report_mismatch("payload_byte", {1'b0, payload_byte_o},
                          {1'b0, want_res.payload_byte});
        if (control_byte_o !== want_res.control_byte)
          report_mismatch("control_byte", {1'b0, control_byte_o},
                          {1'b0, want_res.control_byte});
        if (frame_length_o !== want_res.frame_length)
          report_mismatch("frame_length", frame_length_o, want_res.frame_length);
        if (status_o !== want_res.status)
          report_mismatch("status", {7'h00, status_o}, {7'h00, want_res.status});
        if (last_o !== want_res.last)
          report_mismatch("last", {8'h00, last_o}, {8'h00, want_res.last});
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset once, run the tests in turn, let the tail settle, then judge.
  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed_frames();
    test_back_to_back();
    test_longest_frame();
    test_random_traffic();
    test_output_backpressure();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bfrc_pkg.sv
rtl/bfrc_parser.sv
rtl/bfrc_out_buf.sv
rtl/block_frame_receive_checker_top.sv
sim/block_frame_receive_checker_top_test.sv
